// ===== rtl/pidaw_pkg.sv =====
package pidaw_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  // Integral holds the limits scaled by the gain fraction.
  localparam int unsigned INTEG_W = DATA_W + FRAC_W;
  // Error and measurement step carry one extra bit.
  localparam int unsigned ERR_W   = DATA_W + 1;
  localparam int unsigned PROD_W  = GAIN_W + 1 + ERR_W;
  localparam int unsigned ACC_W   = PROD_W + 2;

  localparam logic signed [DATA_W-1:0] RESET_OUT_HIGH = DATA_W'(255);
  localparam logic [PERIOD_W-1:0]      RESET_PERIOD   = PERIOD_W'(100);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_OUT_LOW        = 3'd3,
    REG_OUT_HIGH       = 3'd4,
    REG_REVERSE_ACTING = 3'd5,
    REG_SAMPLE_PERIOD  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] measurement;
    logic signed [DATA_W-1:0] setpoint;
    logic                     auto_mode;
    logic signed [DATA_W-1:0] manual_output;
  } tick_item_t;

  // Upper bound is tested first, so inverted limits still give a defined result.
  function automatic logic signed [ACC_W-1:0] clamp_acc(
    input logic signed [ACC_W-1:0] v,
    input logic signed [ACC_W-1:0] lo,
    input logic signed [ACC_W-1:0] hi
  );
    logic signed [ACC_W-1:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/pid_controller_antiwindup.sv =====
// PID controller with anti-windup and derivative on measurement. Each accepted
// input item is one control tick; the block takes one tick per clock cycle
// while the output is not stalled and returns one result per tick from the
// result register behind the input register. The whole update - error, three
// 17x17 products, integral add and clamp, output sum, floor and clamp - runs in
// the single combinational pass between those registers, since the next tick
// needs the integral, previous measurement and tick count that this one leaves.
// Gains are unsigned Q8.8 per sample; the integral keeps 8 fraction bits and
// is clamped to the output limits. Write limits and gains only while idle.
module pid_controller_antiwindup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pidaw_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pidaw_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  // tick input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pidaw_pkg::DATA_W-1:0] measurement_i,
  input  logic signed [pidaw_pkg::DATA_W-1:0] setpoint_i,
  input  logic                                auto_mode_i,
  input  logic signed [pidaw_pkg::DATA_W-1:0] manual_output_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [pidaw_pkg::DATA_W-1:0] drive_o,
  output logic                                computed_o
);

  // configuration registers
  logic [pidaw_pkg::GAIN_W-1:0]          prop_gain_q, integ_gain_q, deriv_gain_q;
  logic signed [pidaw_pkg::DATA_W-1:0]   out_low_q, out_high_q;
  logic                                  reverse_q;
  logic [pidaw_pkg::PERIOD_W-1:0]        period_q;

  // controller state
  logic signed [pidaw_pkg::INTEG_W-1:0]  integ_q, integ_d;
  logic signed [pidaw_pkg::DATA_W-1:0]   prev_meas_q, prev_meas_d;
  logic [pidaw_pkg::PERIOD_W-1:0]        tick_q, tick_d;
  logic                                  was_auto_q, was_auto_d;
  logic signed [pidaw_pkg::DATA_W-1:0]   held_q, held_d;

  // pipeline registers
  logic                                  s1_valid_q;
  pidaw_pkg::tick_item_t                 s1_item_q;
  logic                                  out_valid_q;
  logic signed [pidaw_pkg::DATA_W-1:0]   drive_q;
  logic                                  computed_q;

  logic out_free, s1_fire, in_fire;
  logic upd;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign computed_o  = computed_q;
  assign pready      = 1'b1;

  // ---------------------------------------------------------------------------
  // configuration port
  logic                                cfg_wr;
  pidaw_pkg::reg_idx_e                 cfg_idx;
  logic signed [pidaw_pkg::DATA_W-1:0] new_lo, new_hi;
  logic                                cfg_clamp;
  logic signed [pidaw_pkg::ACC_W-1:0]  cfg_held_w, cfg_integ_w;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = pidaw_pkg::reg_idx_e'(paddr[pidaw_pkg::CFG_ADDR_W-1:2]);

  always_comb begin
    new_lo    = out_low_q;
    new_hi    = out_high_q;
    cfg_clamp = 1'b0;
    if (cfg_wr && cfg_idx == pidaw_pkg::REG_OUT_LOW) begin
      new_lo    = pidaw_pkg::DATA_W'(pwdata);
      cfg_clamp = was_auto_q;
    end
    if (cfg_wr && cfg_idx == pidaw_pkg::REG_OUT_HIGH) begin
      new_hi    = pidaw_pkg::DATA_W'(pwdata);
      cfg_clamp = was_auto_q;
    end
    // only valid limits pull the state in at write time
    if (!(new_lo < new_hi)) begin
      cfg_clamp = 1'b0;
    end
    cfg_held_w  = pidaw_pkg::clamp_acc(pidaw_pkg::ACC_W'(held_q),
                                       pidaw_pkg::ACC_W'(new_lo),
                                       pidaw_pkg::ACC_W'(new_hi));
    cfg_integ_w = pidaw_pkg::clamp_acc(pidaw_pkg::ACC_W'(integ_q),
                                       pidaw_pkg::ACC_W'(new_lo) <<< pidaw_pkg::FRAC_W,
                                       pidaw_pkg::ACC_W'(new_hi) <<< pidaw_pkg::FRAC_W);
  end

  always_comb begin
    unique case (pidaw_pkg::reg_idx_e'(paddr[pidaw_pkg::CFG_ADDR_W-1:2]))
      pidaw_pkg::REG_PROP_GAIN:      prdata = pidaw_pkg::CFG_DATA_W'(prop_gain_q);
      pidaw_pkg::REG_INTEG_GAIN:     prdata = pidaw_pkg::CFG_DATA_W'(integ_gain_q);
      pidaw_pkg::REG_DERIV_GAIN:     prdata = pidaw_pkg::CFG_DATA_W'(deriv_gain_q);
      pidaw_pkg::REG_OUT_LOW:        prdata = pidaw_pkg::CFG_DATA_W'(unsigned'(out_low_q));
      pidaw_pkg::REG_OUT_HIGH:       prdata = pidaw_pkg::CFG_DATA_W'(unsigned'(out_high_q));
      pidaw_pkg::REG_REVERSE_ACTING: prdata = pidaw_pkg::CFG_DATA_W'(reverse_q);
      pidaw_pkg::REG_SAMPLE_PERIOD:  prdata = pidaw_pkg::CFG_DATA_W'(period_q);
      default:                       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // one controller step
  logic                                edge_auto;
  logic signed [pidaw_pkg::ACC_W-1:0]  lo_w, hi_w, lo_s, hi_s;
  logic signed [pidaw_pkg::ACC_W-1:0]  man_clamp_w;
  logic signed [pidaw_pkg::INTEG_W-1:0] integ_base;
  logic signed [pidaw_pkg::DATA_W-1:0] prev_base, held_base;
  logic [pidaw_pkg::PERIOD_W-1:0]      tick_inc;
  logic signed [pidaw_pkg::ERR_W-1:0]  err, dmeas, err_s, dmeas_s;
  logic signed [pidaw_pkg::PROD_W-1:0] p_prod, i_prod, d_prod;
  logic signed [pidaw_pkg::ACC_W-1:0]  integ_sum, integ_new_w, acc, acc_fl, drive_w;
  logic signed [pidaw_pkg::INTEG_W-1:0] integ_new;
  logic signed [pidaw_pkg::DATA_W-1:0] drive_new;

  always_comb begin
    lo_w = pidaw_pkg::ACC_W'(out_low_q);
    hi_w = pidaw_pkg::ACC_W'(out_high_q);
    lo_s = lo_w <<< pidaw_pkg::FRAC_W;
    hi_s = hi_w <<< pidaw_pkg::FRAC_W;

    // bumpless entry into auto mode
    edge_auto   = s1_item_q.auto_mode && !was_auto_q;
    man_clamp_w = pidaw_pkg::clamp_acc(pidaw_pkg::ACC_W'(s1_item_q.manual_output), lo_w, hi_w);
    integ_base  = edge_auto ? pidaw_pkg::INTEG_W'(man_clamp_w <<< pidaw_pkg::FRAC_W) : integ_q;
    prev_base   = edge_auto ? s1_item_q.measurement : prev_meas_q;
    held_base   = (edge_auto || !s1_item_q.auto_mode) ? s1_item_q.manual_output : held_q;

    tick_inc = (tick_q < period_q) ? tick_q + pidaw_pkg::PERIOD_W'(1) : tick_q;
    upd      = s1_item_q.auto_mode && (tick_inc >= period_q);

    err     = pidaw_pkg::ERR_W'(s1_item_q.setpoint) - pidaw_pkg::ERR_W'(s1_item_q.measurement);
    dmeas   = pidaw_pkg::ERR_W'(s1_item_q.measurement) - pidaw_pkg::ERR_W'(prev_base);
    // reverse acting: negate the operands rather than the gains
    err_s   = reverse_q ? -err : err;
    dmeas_s = reverse_q ? -dmeas : dmeas;

    p_prod = $signed({1'b0, prop_gain_q}) * err_s;
    i_prod = $signed({1'b0, integ_gain_q}) * err_s;
    d_prod = $signed({1'b0, deriv_gain_q}) * dmeas_s;

    integ_sum   = pidaw_pkg::ACC_W'(integ_base) + pidaw_pkg::ACC_W'(i_prod);
    integ_new_w = pidaw_pkg::clamp_acc(integ_sum, lo_s, hi_s);
    integ_new   = pidaw_pkg::INTEG_W'(integ_new_w);

    acc       = pidaw_pkg::ACC_W'(p_prod) - pidaw_pkg::ACC_W'(d_prod)
              + pidaw_pkg::ACC_W'(integ_new);
    acc_fl    = acc >>> pidaw_pkg::FRAC_W;
    drive_w   = pidaw_pkg::clamp_acc(acc_fl, lo_w, hi_w);
    drive_new = pidaw_pkg::DATA_W'(drive_w);

    integ_d     = upd ? integ_new : integ_base;
    prev_meas_d = upd ? s1_item_q.measurement : prev_base;
    held_d      = upd ? drive_new : held_base;
    tick_d      = upd ? '0 : tick_inc;
    was_auto_d  = s1_item_q.auto_mode;
  end

  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= '0;
      integ_gain_q <= '0;
      deriv_gain_q <= '0;
      out_low_q    <= '0;
      out_high_q   <= pidaw_pkg::RESET_OUT_HIGH;
      reverse_q    <= 1'b0;
      period_q     <= pidaw_pkg::RESET_PERIOD;
      integ_q      <= '0;
      prev_meas_q  <= '0;
      tick_q       <= pidaw_pkg::RESET_PERIOD;
      was_auto_q   <= 1'b0;
      held_q       <= '0;
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          pidaw_pkg::REG_PROP_GAIN:      prop_gain_q  <= pidaw_pkg::GAIN_W'(pwdata);
          pidaw_pkg::REG_INTEG_GAIN:     integ_gain_q <= pidaw_pkg::GAIN_W'(pwdata);
          pidaw_pkg::REG_DERIV_GAIN:     deriv_gain_q <= pidaw_pkg::GAIN_W'(pwdata);
          pidaw_pkg::REG_OUT_LOW:        out_low_q    <= new_lo;
          pidaw_pkg::REG_OUT_HIGH:       out_high_q   <= new_hi;
          pidaw_pkg::REG_REVERSE_ACTING: reverse_q    <= pwdata[0];
          pidaw_pkg::REG_SAMPLE_PERIOD:  period_q     <= pidaw_pkg::PERIOD_W'(pwdata);
          default: ;
        endcase
      end

      if (s1_fire) begin
        integ_q     <= integ_d;
        prev_meas_q <= prev_meas_d;
        tick_q      <= tick_d;
        was_auto_q  <= was_auto_d;
        held_q      <= held_d;
      end else if (cfg_clamp) begin
        held_q  <= pidaw_pkg::DATA_W'(cfg_held_w);
        integ_q <= pidaw_pkg::INTEG_W'(cfg_integ_w);
      end

      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q.measurement   <= measurement_i;
      s1_item_q.setpoint      <= setpoint_i;
      s1_item_q.auto_mode     <= auto_mode_i;
      s1_item_q.manual_output <= manual_output_i;
    end
    if (s1_fire) begin
      drive_q    <= held_d;
      computed_q <= upd;
    end
  end

  // ---------------------------------------------------------------------------
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  a_update_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && upd) |=> (tick_q == '0 && was_auto_q && computed_q))
    else $error("update did not clear tick count or flag the result");

  a_result_follows_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> (out_valid_q && drive_q == held_q))
    else $error("result register does not match held drive");

  a_drive_in_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && computed_o && out_low_q < out_high_q)
      |-> (drive_o >= out_low_q && drive_o <= out_high_q))
    else $error("computed drive outside limits");

endmodule

// ===== tb/sv/pidaw_checker.sv =====
`timescale 1ns / 100ps

module pidaw_checker
  import pidaw_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic                       pready_i,
  input  logic [CFG_ADDR_W-1:0]      paddr_i,
  input  logic [CFG_DATA_W-1:0]      pwdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic signed [DATA_W-1:0]   measurement_i,
  input  logic signed [DATA_W-1:0]   setpoint_i,
  input  logic                       auto_mode_i,
  input  logic signed [DATA_W-1:0]   manual_output_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [DATA_W-1:0]   drive_i,
  input  logic                       computed_i,
  output int unsigned                pending_o,
  output int unsigned                mismatches_o
);

  typedef logic signed [47:0] wide_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     computed;
  } drive_result_t;

  drive_result_t drive_q[$];
  int unsigned   mismatch_cnt;

  // Controller settings
  logic [GAIN_W-1:0]        kp_r;
  logic [GAIN_W-1:0]        ki_r;
  logic [GAIN_W-1:0]        kd_r;
  logic signed [DATA_W-1:0] lim_lo;
  logic signed [DATA_W-1:0] lim_hi;
  logic                     reverse_r;
  logic [PERIOD_W-1:0]      period_r;

  // Controller state
  wide_t                    integ_r;
  logic signed [DATA_W-1:0] last_meas;
  logic signed [DATA_W-1:0] held_drive;
  logic [PERIOD_W-1:0]      ticks_r;
  logic                     auto_r;

  // Upper bound first, so inverted limits still resolve
  function automatic wide_t clamp_to(input wide_t v, input wide_t lo, input wide_t hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic write_setting(input logic [REG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
    wide_t lo_w;
    wide_t hi_w;
    case (idx)
      REG_PROP_GAIN:      kp_r = data[GAIN_W-1:0];
      REG_INTEG_GAIN:     ki_r = data[GAIN_W-1:0];
      REG_DERIV_GAIN:     kd_r = data[GAIN_W-1:0];
      REG_OUT_LOW:        lim_lo = data[DATA_W-1:0];
      REG_OUT_HIGH:       lim_hi = data[DATA_W-1:0];
      REG_REVERSE_ACTING: reverse_r = data[0];
      REG_SAMPLE_PERIOD:  period_r = data[PERIOD_W-1:0];
      default:            return;
    endcase
    lo_w = wide_t'(lim_lo);
    hi_w = wide_t'(lim_hi);
    // Pull state inside new limits, but only when they are ordered
    if ((idx == REG_OUT_LOW || idx == REG_OUT_HIGH) && auto_r && lo_w < hi_w) begin
      held_drive = DATA_W'(clamp_to(wide_t'(held_drive), lo_w, hi_w));
      integ_r    = clamp_to(integ_r, lo_w <<< FRAC_W, hi_w <<< FRAC_W);
    end
  endtask

  task automatic pid_tick(input tick_item_t t, output drive_result_t r);
    wide_t lo_w;
    wide_t hi_w;
    wide_t kp;
    wide_t ki;
    wide_t kd;
    wide_t err;
    wide_t acc;
    lo_w = wide_t'(lim_lo);
    hi_w = wide_t'(lim_hi);
    // Bumpless transfer into auto
    if (t.auto_mode && !auto_r) begin
      integ_r    = clamp_to(wide_t'(t.manual_output), lo_w, hi_w) <<< FRAC_W;
      last_meas  = t.measurement;
      held_drive = t.manual_output;
    end
    if (!t.auto_mode) begin
      held_drive = t.manual_output;
    end
    auto_r = t.auto_mode;
    if (ticks_r < period_r) begin
      ticks_r = ticks_r + 1'b1;
    end
    r.computed = 1'b0;
    if (t.auto_mode && ticks_r >= period_r) begin
      kp = wide_t'(kp_r);
      ki = wide_t'(ki_r);
      kd = wide_t'(kd_r);
      if (reverse_r) begin
        kp = -kp;
        ki = -ki;
        kd = -kd;
      end
      err     = wide_t'(t.setpoint) - wide_t'(t.measurement);
      integ_r = clamp_to(integ_r + ki * err, lo_w <<< FRAC_W, hi_w <<< FRAC_W);
      acc     = kp * err + integ_r - kd * (wide_t'(t.measurement) - wide_t'(last_meas));
      held_drive = DATA_W'(clamp_to(acc >>> FRAC_W, lo_w, hi_w));
      last_meas  = t.measurement;
      ticks_r    = '0;
      r.computed = 1'b1;
    end
    r.drive = held_drive;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tick_item_t    item;
    drive_result_t want;
    drive_result_t next;
    if (!rst_ni) begin
      drive_q.delete();
      mismatch_cnt = 0;
      kp_r       = '0;
      ki_r       = '0;
      kd_r       = '0;
      lim_lo     = '0;
      lim_hi     = RESET_OUT_HIGH;
      reverse_r  = 1'b0;
      period_r   = RESET_PERIOD;
      integ_r    = '0;
      last_meas  = '0;
      held_drive = '0;
      ticks_r    = RESET_PERIOD;
      auto_r     = 1'b0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        write_setting(paddr_i[CFG_ADDR_W-1:2], pwdata_i);
      end
      // Retire results before queuing the tick taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          $error("result with no tick waiting: drive %0d, computed %0d", drive_i, computed_i);
          mismatch_cnt++;
        end else begin
          want = drive_q.pop_front();
          if (drive_i !== want.drive) begin
            $error("drive: expected %0d, actual %0d", want.drive, drive_i);
            mismatch_cnt++;
          end
          if (computed_i !== want.computed) begin
            $error("computed: expected %0d, actual %0d", want.computed, computed_i);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        item.measurement   = measurement_i;
        item.setpoint      = setpoint_i;
        item.auto_mode     = auto_mode_i;
        item.manual_output = manual_output_i;
        pid_tick(item, next);
        drive_q.push_back(next);
      end
      pending_o    <= drive_q.size();
      mismatches_o <= mismatch_cnt;
    end
  end

endmodule

// ===== tb/sv/pid_controller_antiwindup_tb.sv =====
`timescale 1ns / 100ps

module pid_controller_antiwindup_tb;
  import pidaw_pkg::*;

  localparam int unsigned LATENCY     = 2;
  localparam int unsigned LONG_HOLD   = 120;
  localparam int unsigned PHASES      = 11;
  localparam int unsigned PHASE_TICKS = 48;
  localparam int unsigned HOLD_PHASE  = 3;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                      clk_i   = 1'b0;
  logic                      rst_ni  = 1'b0;
  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]     paddr   = '0;
  logic [CFG_DATA_W-1:0]     pwdata  = '0;
  logic [CFG_DATA_W-1:0]     prdata;
  logic                      pready;
  logic                      in_valid_i      = 1'b0;
  logic                      in_stall_o;
  logic signed [DATA_W-1:0]  measurement_i   = '0;
  logic signed [DATA_W-1:0]  setpoint_i      = '0;
  logic                      auto_mode_i     = 1'b0;
  logic signed [DATA_W-1:0]  manual_output_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i     = 1'b0;
  logic signed [DATA_W-1:0]  drive_o;
  logic                      computed_o;

  int unsigned pending;
  int unsigned mismatches;

  bit idle_on     = 1'b1;
  bit hold_req    = 1'b0;
  bit hold_active = 1'b0;

  int unsigned              phase;
  int unsigned              wait_cycles;
  int                       lo_v;
  int                       hi_v;
  logic                     auto_now;
  logic signed [DATA_W-1:0] sp_now;
  logic signed [DATA_W-1:0] meas_v;
  logic signed [DATA_W-1:0] man_v;

  pid_controller_antiwindup i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_stall_o,
    .measurement_i,
    .setpoint_i,
    .auto_mode_i,
    .manual_output_i,
    .out_valid_o,
    .out_stall_i,
    .drive_o,
    .computed_o
  );

  pidaw_checker i_checker (
    .clk_i,
    .rst_ni,
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .measurement_i   (measurement_i),
    .setpoint_i      (setpoint_i),
    .auto_mode_i     (auto_mode_i),
    .manual_output_i (manual_output_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_i         (drive_o),
    .computed_i      (computed_o),
    .pending_o       (pending),
    .mismatches_o    (mismatches)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[pid_controller_antiwindup] ERROR");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_active = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper bits carry noise; the block must ignore them
  task automatic program_loop(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic signed [DATA_W-1:0] lo,
                              input logic signed [DATA_W-1:0] hi, input logic rev,
                              input logic [PERIOD_W-1:0] period);
    apb_write(REG_PROP_GAIN,      {16'($urandom), kp});
    apb_write(REG_INTEG_GAIN,     {16'($urandom), ki});
    apb_write(REG_DERIV_GAIN,     {16'($urandom), kd});
    apb_write(REG_OUT_LOW,        {16'($urandom), lo});
    apb_write(REG_OUT_HIGH,       {16'($urandom), hi});
    apb_write(REG_REVERSE_ACTING, {31'($urandom), rev});
    apb_write(REG_SAMPLE_PERIOD,  {16'($urandom), period});
  endtask

  task automatic send_tick(input logic signed [DATA_W-1:0] meas,
                           input logic signed [DATA_W-1:0] sp, input logic am,
                           input logic signed [DATA_W-1:0] man);
    in_valid_i      <= 1'b1;
    measurement_i   <= meas;
    setpoint_i      <= sp;
    auto_mode_i     <= am;
    manual_output_i <= man;
    do @(posedge clk_i); while (in_stall_o);
    if (idle_on && !hold_req && !hold_active && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Stop offering and let every result come back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 16'h0400));
    endcase
  endfunction

  function automatic logic [PERIOD_W-1:0] rand_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      9:       return '1;
      8:       return PERIOD_W'($urandom_range(7, 40));
      default: return PERIOD_W'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: the first auto tick updates at once
    send_tick(0, 0, 1'b0, 1234);
    send_tick(100, 200, 1'b1, 300);
    send_tick(-32768, 32767, 1'b1, 0);
    send_tick(32767, -32768, 1'b0, -32768);
    send_tick(0, 0, 1'b0, 32767);
    drain();

    // Full gains, full range, zero period
    program_loop('1, '1, '1, -32768, 32767, 1'b0, '0);
    send_tick(0, 0, 1'b1, -32768);
    send_tick(-32768, 32767, 1'b1, 0);
    send_tick(32767, -32768, 1'b1, 0);
    send_tick(32767, 32767, 1'b1, 5);
    send_tick(-32768, -32768, 1'b1, 5);
    drain();

    // Reverse acting
    program_loop(16'h0100, 16'h0040, 16'h0080, -1000, 1000, 1'b1, 16'd3);
    send_tick(10, 500, 1'b1, 0);
    send_tick(20, 500, 1'b1, 0);
    send_tick(30, 500, 1'b1, 0);
    send_tick(900, -500, 1'b1, 0);
    drain();

    // Limits inverted while in auto: only the first, still ordered write clamps
    apb_write(REG_OUT_LOW, 32'd100);
    apb_write(REG_OUT_HIGH, -32'sd100);
    send_tick(0, 300, 1'b1, 0);
    send_tick(0, -300, 1'b1, 0);
    send_tick(50, 0, 1'b0, 7);
    send_tick(50, 0, 1'b1, 7);
    drain();

    // Counter runs in manual, then the period drops below it
    apb_write(REG_OUT_LOW, -32'sd500);
    apb_write(REG_OUT_HIGH, 32'd500);
    apb_write(REG_SAMPLE_PERIOD, 32'd40);
    send_tick(0, 0, 1'b0, 600);
    send_tick(0, 0, 1'b0, -600);
    drain();
    apb_write(REG_SAMPLE_PERIOD, 32'd2);
    apb_write(REG_UNUSED, '1);
    send_tick(-40, 40, 1'b1, 200);
    send_tick(-30, 40, 1'b1, 200);

    auto_now = 1'b1;
    sp_now   = '0;
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase == PHASES - 1) begin
        idle_on = 1'b0;
      end
      case ($urandom_range(0, 7))
        0: begin
          lo_v = -32768;
          hi_v = 32767;
        end
        1: begin
          lo_v = int'($urandom);
          hi_v = int'($urandom);
        end
        2: begin
          lo_v = $urandom_range(0, 2000) - 1000;
          hi_v = lo_v;
        end
        default: begin
          lo_v = $urandom_range(0, 3000) - 2000;
          hi_v = lo_v + $urandom_range(1, 3000);
        end
      endcase
      program_loop(rand_gain(), rand_gain(), rand_gain(), DATA_W'(lo_v), DATA_W'(hi_v),
                   1'($urandom), rand_period());
      // Back up the result side while ticks keep coming
      if (phase == HOLD_PHASE) begin
        hold_req = 1'b1;
      end
      repeat (PHASE_TICKS) begin
        if ($urandom_range(0, 9) == 0) begin
          auto_now = !auto_now;
        end
        if ($urandom_range(0, 7) == 0) begin
          sp_now = DATA_W'($urandom);
        end
        if ($urandom_range(0, 5) == 0) begin
          meas_v = DATA_W'($urandom);
        end else begin
          meas_v = DATA_W'(sp_now + $urandom_range(0, 400) - 200);
        end
        if ($urandom_range(0, 3) == 0) begin
          man_v = DATA_W'($urandom);
        end else begin
          man_v = DATA_W'($urandom_range(0, 600) - 300);
        end
        send_tick(meas_v, sp_now, auto_now, man_v);
      end
    end

    in_valid_i <= 1'b0;
    for (wait_cycles = 0; pending != 0 && wait_cycles < 10000; wait_cycles++) begin
      @(posedge clk_i);
    end
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("[pid_controller_antiwindup] OK");
    end else begin
      $display("[pid_controller_antiwindup] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pidaw_pkg.sv
rtl/pid_controller_antiwindup.sv
tb/sv/pidaw_checker.sv
tb/sv/pid_controller_antiwindup_tb.sv
